@@ hw/rtl/tfua_pkg.sv @@
// ----------------------------------------------------------------------------
// tfua_pkg
// Shared codes, side-band type and helper functions for the typed field
// update ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package tfua_pkg;

    // operation codes
    localparam logic [2:0] KIND_ADD = 3'd0;
    localparam logic [2:0] KIND_SUB = 3'd1;
    localparam logic [2:0] KIND_AND = 3'd2;
    localparam logic [2:0] KIND_XOR = 3'd3;
    localparam logic [2:0] KIND_OR  = 3'd4;

    // value type codes
    localparam logic [1:0] TYPE_DBL = 2'd0;
    localparam logic [1:0] TYPE_FLT = 2'd1;
    localparam logic [1:0] TYPE_INT = 2'd2;
    localparam logic [1:0] TYPE_NAN = 2'd3;

    // error codes
    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_TYPE = 2'd1;
    localparam logic [1:0] ERR_OVF  = 2'd2;
    localparam logic [1:0] ERR_DUP  = 2'd3;

    // pipeline depth, output register included
    localparam int NSTAGE = 10;

    localparam logic [63:0] F64_DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
    // 2^128 - 2^103 as binary64 magnitude: rounds to float infinity from here
    localparam logic [62:0] F32_OVF_MAG = {11'h47E, 52'hFFFFFF0000000};

    typedef struct packed {
        logic        sub;
        logic [1:0]  err;
        logic [1:0]  rtype;
        logic [63:0] ibits;
        logic        ineg;
    } t_side;

    function automatic logic [3:0] lzc8(input logic [7:0] x);
        logic [3:0] n;
        logic       hit;
        n   = 4'd8;
        hit = 1'b0;
        for (int i = 7; i >= 0; i--) begin
            if (!hit && x[i]) begin
                n   = 4'(7 - i);
                hit = 1'b1;
            end
        end
        return n;
    endfunction

    // leading zero count in two levels: byte groups, then bits
    function automatic logic [6:0] lzc64(input logic [63:0] x);
        logic [6:0] n;
        logic       hit;
        n   = 7'd64;
        hit = 1'b0;
        for (int g = 7; g >= 0; g--) begin
            if (!hit && x[g*8 +: 8] != 8'd0) begin
                n   = 7'((7 - g) * 8) + {3'd0, lzc8(x[g*8 +: 8])};
                hit = 1'b1;
            end
        end
        return n;
    endfunction

    function automatic logic [3:0] size_uint(input logic [63:0] v);
        if (v <= 64'h7F) return 4'd1;
        if (v <= 64'hFF) return 4'd2;
        if (v <= 64'hFFFF) return 4'd3;
        if (v <= 64'hFFFF_FFFF) return 4'd5;
        return 4'd9;
    endfunction

    function automatic logic [3:0] size_neg(input logic [63:0] v);
        if (v >= 64'hFFFF_FFFF_FFFF_FFE0) return 4'd1;
        if (v >= 64'hFFFF_FFFF_FFFF_FF80) return 4'd2;
        if (v >= 64'hFFFF_FFFF_FFFF_8000) return 4'd3;
        if (v >= 64'hFFFF_FFFF_8000_0000) return 4'd5;
        return 4'd9;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/tfua_to_f64.sv @@
// ----------------------------------------------------------------------------
// tfua_to_f64
// Three-stage converter of a typed operand (double, float or int64) to
// binary64 bits, int64 rounded to nearest even.
// ----------------------------------------------------------------------------
`default_nettype none

module tfua_to_f64 (
    input  wire logic        i_clk,
    input  wire logic [2:0]  i_en,    // load enables of stages 1..3
    input  wire logic [1:0]  i_type,
    input  wire logic [63:0] i_bits,
    input  wire logic        i_neg,
    output logic      [63:0] o_f64
);

    // stage 1: sign and magnitude
    logic        w1_sign;
    logic [63:0] w1_val;
    logic [1:0]  r1_type;
    logic        r1_sign;
    logic [63:0] r1_val;

    assign w1_sign = (i_type == tfua_pkg::TYPE_INT) & i_neg & i_bits[63];
    assign w1_val  = w1_sign ? (~i_bits + 64'd1) : i_bits;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_type <= i_type;
            r1_sign <= w1_sign;
            r1_val  <= w1_val;
        end
    end

    // stage 2: leading zero count for integers, float widening
    logic [6:0]  w2_lz;
    logic [6:0]  w2_lzf;
    logic        w2_fs;
    logic [7:0]  w2_fe;
    logic [22:0] w2_fm;
    logic [22:0] w2_fsh;
    logic [63:0] w2_f64;
    logic        r2_int;
    logic        r2_sign;
    logic [63:0] r2_val;
    logic [5:0]  r2_lz;
    logic [63:0] r2_f64;

    assign w2_lz  = tfua_pkg::lzc64(r1_val);
    assign w2_fs  = r1_val[31];
    assign w2_fe  = r1_val[30:23];
    assign w2_fm  = r1_val[22:0];
    assign w2_lzf = tfua_pkg::lzc64({w2_fm, 41'd0});
    assign w2_fsh = w2_fm << w2_lzf[4:0];

    always_comb begin
        if (r1_type == tfua_pkg::TYPE_DBL) begin
            w2_f64 = r1_val;
        end else if (w2_fe == 8'hFF) begin
            if (w2_fm == 23'd0) w2_f64 = {w2_fs, 11'h7FF, 52'd0};
            else w2_f64 = {w2_fs, 11'h7FF, 1'b1, w2_fm[21:0], 29'd0};
        end else if (w2_fe == 8'd0) begin
            if (w2_fm == 23'd0) w2_f64 = {w2_fs, 63'd0};
            else w2_f64 = {w2_fs, 11'd896 - {6'd0, w2_lzf[4:0]}, w2_fsh[21:0], 30'd0};
        end else begin
            w2_f64 = {w2_fs, {3'd0, w2_fe} + 11'd896, w2_fm, 29'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r2_int  <= (r1_type == tfua_pkg::TYPE_INT);
            r2_sign <= r1_sign;
            r2_val  <= r1_val;
            r2_lz   <= w2_lz[5:0];
            r2_f64  <= w2_f64;
        end
    end

    // stage 3: normalise and round the integer to 53 bits
    logic [63:0] w3_norm;
    logic        w3_up;
    logic [62:0] w3_rnd;
    logic [63:0] w3_int;
    logic [63:0] r3_f64;

    assign w3_norm = r2_val << r2_lz;
    assign w3_up   = w3_norm[10] & (w3_norm[11] | (|w3_norm[9:0]));
    assign w3_rnd  = {11'd1086 - {5'd0, r2_lz}, w3_norm[62:11]} + {62'd0, w3_up};
    assign w3_int  = (r2_val == 64'd0) ? 64'd0 : {r2_sign, w3_rnd};

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r3_f64 <= r2_int ? w3_int : r2_f64;
        end
    end

    assign o_f64 = r3_f64;

endmodule

`default_nettype wire

@@ hw/rtl/typed_field_update_alu.sv @@
// ----------------------------------------------------------------------------
// typed_field_update_alu
// Arithmetic and bitwise update of a typed numeric field with error code and
// MessagePack size of the new value.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one update per transaction: tuser holds kind,
//   old_type and arg_type, tdata the operand values and flags. Master stream
//   returns one result per transaction: tuser is result_type, tdata the
//   value, negative flag, error code and encoded size.
//   The pipe takes one transaction every cycle unless a stalled master has
//   filled it; the depth is set by the binary64 add path (operand
//   conversion, align, add, leading zero count, normalise and round,
//   narrowing to binary32, output register).
//   Each stage has its own valid bit and advances when its successor has
//   room, so a stalled master holds its result while bubbles further back
//   are squeezed out and the slave side keeps accepting until the pipe is
//   full. Synchronous active-low reset empties the pipe; no data is lost or
//   repeated under any stall pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module typed_field_update_alu (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // [63:0] old_bits, [64] old_negative, [128:65] arg_bits,
    // [129] arg_negative, [130] already_updated, [135:131] zero
    input  wire logic [135:0] i_s_axis_tdata,
    // [2:0] kind, [4:3] old_type, [6:5] arg_type
    input  wire logic [6:0]   i_s_axis_tuser,
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // [63:0] result_bits, [64] result_negative, [66:65] error,
    // [70:67] encoded_size, [71] zero
    output logic      [71:0]  o_m_axis_tdata,
    // [1:0] result_type
    output logic      [1:0]   o_m_axis_tuser
);

    localparam int NS = tfua_pkg::NSTAGE;

    typedef struct packed {
        logic        spec;
        logic [63:0] spec_bits;
        logic        sign;
        logic [10:0] exp;
        logic        zsign;
    } t_fctl;

    // ---------------- flow control ----------------
    logic [NS:1] r_vld;
    logic [NS:1] w_en;

    always_comb begin
        w_en[NS] = ~r_vld[NS] | i_m_axis_tready;
        for (int k = NS - 1; k >= 1; k--) begin
            w_en[k] = ~r_vld[k] | w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[1]) r_vld[1] <= i_s_axis_tvalid;
            for (int k = 2; k <= NS; k++) begin
                if (w_en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    assign o_s_axis_tready = w_en[1];
    assign o_m_axis_tvalid = r_vld[NS];

    // ---------------- stage 1: decode, checks, integer result ----------------
    logic [2:0]  w_kind;
    logic [1:0]  w_otype;
    logic [1:0]  w_atype;
    logic [63:0] w_obits;
    logic [63:0] w_abits;
    logic        w_oneg;
    logic        w_aneg;
    logic        w_dup;
    logic        w_sub;
    logic [1:0]  w_low;
    logic [65:0] w_sum;
    tfua_pkg::t_side n_side;
    tfua_pkg::t_side r_side [1:NS-1];

    assign w_kind  = i_s_axis_tuser[2:0];
    assign w_otype = i_s_axis_tuser[4:3];
    assign w_atype = i_s_axis_tuser[6:5];
    assign w_obits = i_s_axis_tdata[63:0];
    assign w_oneg  = i_s_axis_tdata[64];
    assign w_abits = i_s_axis_tdata[128:65];
    assign w_aneg  = i_s_axis_tdata[129];
    assign w_dup   = i_s_axis_tdata[130];
    assign w_sub   = (w_kind == tfua_pkg::KIND_SUB);
    assign w_low   = (w_otype < w_atype) ? w_otype : w_atype;

    // exact 66-bit signed sum; subtract as add of the inverted operand plus one
    assign w_sum = {{2{w_oneg & w_obits[63]}}, w_obits}
                 + ({{2{w_aneg & w_abits[63]}}, w_abits} ^ {66{w_sub}})
                 + {65'd0, w_sub};

    always_comb begin
        n_side.sub   = w_sub;
        n_side.err   = tfua_pkg::ERR_NONE;
        n_side.rtype = tfua_pkg::TYPE_INT;
        n_side.ibits = 64'd0;
        n_side.ineg  = 1'b0;
        if (w_kind > tfua_pkg::KIND_OR) begin
            n_side.err = tfua_pkg::ERR_TYPE;
        end else if (w_kind == tfua_pkg::KIND_AND || w_kind == tfua_pkg::KIND_XOR
                     || w_kind == tfua_pkg::KIND_OR) begin
            if (w_atype != tfua_pkg::TYPE_INT || w_aneg) begin
                n_side.err = tfua_pkg::ERR_TYPE;
            end else if (w_dup) begin
                n_side.err = tfua_pkg::ERR_DUP;
            end else if (w_otype != tfua_pkg::TYPE_INT || w_oneg) begin
                n_side.err = tfua_pkg::ERR_TYPE;
            end else begin
                case (w_kind)
                    tfua_pkg::KIND_AND: n_side.ibits = w_obits & w_abits;
                    tfua_pkg::KIND_XOR: n_side.ibits = w_obits ^ w_abits;
                    default:            n_side.ibits = w_obits | w_abits;
                endcase
            end
        end else begin
            if (w_atype == tfua_pkg::TYPE_NAN) begin
                n_side.err = tfua_pkg::ERR_TYPE;
            end else if (w_dup) begin
                n_side.err = tfua_pkg::ERR_DUP;
            end else if (w_otype == tfua_pkg::TYPE_NAN) begin
                n_side.err = tfua_pkg::ERR_TYPE;
            end else begin
                n_side.rtype = w_low;
                if (w_low == tfua_pkg::TYPE_INT) begin
                    if (w_sum[65:64] == 2'b00) begin
                        n_side.ibits = w_sum[63:0];
                    end else if (w_sum[65:63] == 3'b111) begin
                        n_side.ibits = w_sum[63:0];
                        n_side.ineg  = 1'b1;
                    end else begin
                        n_side.err = tfua_pkg::ERR_OVF;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) r_side[1] <= n_side;
        for (int k = 2; k < NS; k++) begin
            if (w_en[k]) r_side[k] <= r_side[k-1];
        end
    end

    // ---------------- stages 1..3: operands to binary64 ----------------
    logic [63:0] w_fa;
    logic [63:0] w_fb;

    tfua_to_f64 u_conv_old (
        .i_clk  (i_clk),
        .i_en   (w_en[3:1]),
        .i_type (w_otype),
        .i_bits (w_obits),
        .i_neg  (w_oneg),
        .o_f64  (w_fa)
    );

    tfua_to_f64 u_conv_arg (
        .i_clk  (i_clk),
        .i_en   (w_en[3:1]),
        .i_type (w_atype),
        .i_bits (w_abits),
        .i_neg  (w_aneg),
        .o_f64  (w_fb)
    );

    // ---------------- stage 4: specials, swap, exponent difference ----------------
    logic [10:0] w4_ea;
    logic [10:0] w4_eb;
    logic [51:0] w4_ma;
    logic [51:0] w4_mb;
    logic        w4_sa;
    logic        w4_sb;
    logic        w4_nan_a;
    logic        w4_nan_b;
    logic        w4_inf_a;
    logic        w4_inf_b;
    logic        w4_age;
    logic [10:0] w4_xa;
    logic [10:0] w4_xb;
    logic [52:0] w4_fa;
    logic [52:0] w4_fb;
    t_fctl       n4_ctl;
    logic [52:0] n4_big;
    logic [52:0] n4_sml;
    logic [10:0] n4_d;
    t_fctl       r4_ctl;
    logic [52:0] r4_big;
    logic [52:0] r4_sml;
    logic [10:0] r4_d;
    logic        r4_esub;

    assign w4_ea    = w_fa[62:52];
    assign w4_eb    = w_fb[62:52];
    assign w4_ma    = w_fa[51:0];
    assign w4_mb    = w_fb[51:0];
    assign w4_sa    = w_fa[63];
    assign w4_sb    = w_fb[63] ^ r_side[3].sub;
    assign w4_nan_a = (w4_ea == 11'h7FF) && (w4_ma != 52'd0);
    assign w4_nan_b = (w4_eb == 11'h7FF) && (w4_mb != 52'd0);
    assign w4_inf_a = (w4_ea == 11'h7FF) && (w4_ma == 52'd0);
    assign w4_inf_b = (w4_eb == 11'h7FF) && (w4_mb == 52'd0);
    assign w4_age   = (w_fa[62:0] >= w_fb[62:0]);
    assign w4_xa    = (w4_ea == 11'd0) ? 11'd1 : w4_ea;
    assign w4_xb    = (w4_eb == 11'd0) ? 11'd1 : w4_eb;
    assign w4_fa    = {w4_ea != 11'd0, w4_ma};
    assign w4_fb    = {w4_eb != 11'd0, w4_mb};

    always_comb begin
        n4_ctl.spec      = 1'b1;
        n4_ctl.spec_bits = 64'd0;
        // a NaN operand passes through quietened, the first one winning
        if (w4_nan_a) begin
            n4_ctl.spec_bits = w_fa | (64'd1 << 51);
        end else if (w4_nan_b) begin
            n4_ctl.spec_bits = w_fb | (64'd1 << 51);
        end else if (w4_inf_a && w4_inf_b && (w4_sa != w4_sb)) begin
            n4_ctl.spec_bits = tfua_pkg::F64_DEFAULT_NAN;
        end else if (w4_inf_a) begin
            n4_ctl.spec_bits = w_fa;
        end else if (w4_inf_b) begin
            n4_ctl.spec_bits = {w4_sb, 11'h7FF, 52'd0};
        end else begin
            n4_ctl.spec = 1'b0;
        end
        n4_ctl.sign  = w4_age ? w4_sa : w4_sb;
        n4_ctl.exp   = w4_age ? w4_xa : w4_xb;
        n4_ctl.zsign = w4_sa & w4_sb;
        n4_big       = w4_age ? w4_fa : w4_fb;
        n4_sml       = w4_age ? w4_fb : w4_fa;
        n4_d         = w4_age ? (w4_xa - w4_xb) : (w4_xb - w4_xa);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r4_ctl  <= n4_ctl;
            r4_big  <= n4_big;
            r4_sml  <= n4_sml;
            r4_d    <= n4_d;
            r4_esub <= w4_sa ^ w4_sb;
        end
    end

    // ---------------- stage 5: align the smaller operand ----------------
    logic [111:0] w5_ext;
    logic [55:0]  w5_sml;
    t_fctl        r5_ctl;
    logic [55:0]  r5_big;
    logic [55:0]  r5_sml;
    logic         r5_esub;

    assign w5_ext = {r4_sml, 59'd0} >> r4_d[5:0];

    always_comb begin
        if (r4_d > 11'd56) w5_sml = {55'd0, r4_sml != 53'd0};
        else w5_sml = {w5_ext[111:57], |w5_ext[56:0]};
    end

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r5_ctl  <= r4_ctl;
            r5_big  <= {r4_big, 3'd0};
            r5_sml  <= w5_sml;
            r5_esub <= r4_esub;
        end
    end

    // ---------------- stage 6: mantissa add or subtract ----------------
    t_fctl       r6_ctl;
    logic [56:0] r6_res;

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r6_ctl <= r5_ctl;
            r6_res <= r5_esub ? {1'b0, r5_big - r5_sml}
                              : ({1'b0, r5_big} + {1'b0, r5_sml});
        end
    end

    // ---------------- stage 7: leading zero count, shift limit ----------------
    logic [6:0]  w7_lz;
    logic [5:0]  w7_sh;
    t_fctl       r7_ctl;
    logic [56:0] r7_res;
    logic [5:0]  r7_sh;
    logic [10:0] r7_e;
    logic        r7_zero;

    assign w7_lz = tfua_pkg::lzc64({r6_res, 7'd0});
    // stop at the subnormal boundary
    assign w7_sh = ({4'd0, w7_lz} > r6_ctl.exp) ? r6_ctl.exp[5:0] : w7_lz[5:0];

    always_ff @(posedge i_clk) begin
        if (w_en[7]) begin
            r7_ctl  <= r6_ctl;
            r7_res  <= r6_res;
            r7_sh   <= w7_sh;
            r7_e    <= r6_ctl.exp + 11'd1 - {5'd0, w7_sh};
            r7_zero <= (r6_res == 57'd0);
        end
    end

    // ---------------- stage 8: normalise and round to binary64 ----------------
    logic [56:0] w8_n;
    logic [10:0] w8_e;
    logic        w8_up;
    logic [62:0] w8_rnd;
    logic [63:0] w8_c;
    logic [63:0] r8_c;

    assign w8_n   = r7_res << r7_sh;
    assign w8_e   = w8_n[56] ? r7_e : 11'd0;
    assign w8_up  = w8_n[3] & (w8_n[4] | (|w8_n[2:0]));
    assign w8_rnd = {w8_e, w8_n[55:4]} + {62'd0, w8_up};

    always_comb begin
        if (r7_ctl.spec) w8_c = r7_ctl.spec_bits;
        else if (r7_zero) w8_c = {r7_ctl.zsign, 63'd0};
        else if (w8_e == 11'h7FF) w8_c = {r7_ctl.sign, 11'h7FF, 52'd0};
        else w8_c = {r7_ctl.sign, w8_rnd};
    end

    always_ff @(posedge i_clk) begin
        if (w_en[8]) r8_c <= w8_c;
    end

    // ---------------- stage 9: narrow to binary32 ----------------
    logic         w9_s;
    logic [10:0]  w9_e;
    logic [51:0]  w9_f;
    logic         w9_nup;
    logic [30:0]  w9_nrm;
    logic [9:0]   w9_r;
    logic [115:0] w9_ext;
    logic         w9_sup;
    logic [30:0]  w9_sub;
    logic [31:0]  w9_f32;
    logic [63:0]  r9_c;
    logic [31:0]  r9_f;

    assign w9_s   = r8_c[63];
    assign w9_e   = r8_c[62:52];
    assign w9_f   = r8_c[51:0];
    assign w9_nup = w9_f[28] & (w9_f[29] | (|w9_f[27:0]));
    assign w9_nrm = {8'(w9_e - 11'd896), w9_f[51:29]} + {30'd0, w9_nup};
    // binary32 subnormal: shift right so one unit is 2^-149
    assign w9_r   = 10'd926 - ((w9_e == 11'd0) ? 10'd1 : w9_e[9:0]);
    assign w9_ext = {w9_e != 11'd0, w9_f, 63'd0} >> w9_r[5:0];
    assign w9_sup = w9_ext[62] & (w9_ext[63] | (|w9_ext[61:0]));
    assign w9_sub = {8'd0, w9_ext[85:63]} + {30'd0, w9_sup};

    always_comb begin
        if (w9_e == 11'h7FF && w9_f != 52'd0) w9_f32 = {w9_s, 8'hFF, 1'b1, w9_f[50:29]};
        else if (r8_c[62:0] >= tfua_pkg::F32_OVF_MAG) w9_f32 = {w9_s, 8'hFF, 23'd0};
        else if (w9_e > 11'd896) w9_f32 = {w9_s, w9_nrm};
        else if (w9_r >= 10'd64) w9_f32 = {w9_s, 31'd0};
        else w9_f32 = {w9_s, w9_sub};
    end

    always_ff @(posedge i_clk) begin
        if (w_en[9]) begin
            r9_c <= r8_c;
            r9_f <= w9_f32;
        end
    end

    // ---------------- stage 10: result select, output register ----------------
    logic [1:0]  r_out_type;
    logic [63:0] r_out_bits;
    logic        r_out_neg;
    logic [1:0]  r_out_err;
    logic [3:0]  r_out_size;

    always_ff @(posedge i_clk) begin
        if (w_en[NS]) begin
            r_out_err <= r_side[NS-1].err;
            if (r_side[NS-1].err != tfua_pkg::ERR_NONE) begin
                r_out_type <= tfua_pkg::TYPE_DBL;
                r_out_bits <= 64'd0;
                r_out_neg  <= 1'b0;
                r_out_size <= 4'd0;
            end else if (r_side[NS-1].rtype == tfua_pkg::TYPE_INT) begin
                r_out_type <= tfua_pkg::TYPE_INT;
                r_out_bits <= r_side[NS-1].ibits;
                r_out_neg  <= r_side[NS-1].ineg;
                r_out_size <= r_side[NS-1].ineg ? tfua_pkg::size_neg(r_side[NS-1].ibits)
                                                : tfua_pkg::size_uint(r_side[NS-1].ibits);
            end else if (r_side[NS-1].rtype == tfua_pkg::TYPE_DBL) begin
                r_out_type <= tfua_pkg::TYPE_DBL;
                r_out_bits <= r9_c;
                r_out_neg  <= 1'b0;
                r_out_size <= 4'd9;
            end else begin
                r_out_type <= tfua_pkg::TYPE_FLT;
                r_out_bits <= {32'd0, r9_f};
                r_out_neg  <= 1'b0;
                r_out_size <= 4'd5;
            end
        end
    end

    assign o_m_axis_tdata = {1'b0, r_out_size, r_out_err, r_out_neg, r_out_bits};
    assign o_m_axis_tuser = r_out_type;

    // ---------------- assertions ----------------
    a_err_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NS] && r_out_err != tfua_pkg::ERR_NONE)
        |-> (r_out_bits == 64'd0 && r_out_size == 4'd0 && !r_out_neg
             && r_out_type == tfua_pkg::TYPE_DBL))
        else $error("error result carries a payload");

    a_ok_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NS] && r_out_err == tfua_pkg::ERR_NONE) |-> (r_out_size != 4'd0))
        else $error("good result without encoded size");

    a_flt_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NS] && r_out_err == tfua_pkg::ERR_NONE && r_out_type == tfua_pkg::TYPE_FLT)
        |-> (r_out_bits[63:32] == 32'd0 && r_out_size == 4'd5))
        else $error("float result has upper half set");

    a_full_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (&r_vld))
        else $error("input stalled while pipe has a free stage");

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stream-level check of typed_field_update_alu. A queue-fed driver offers
// field updates with random gaps, an independent model predicts
// each result, and a monitor compares every master transaction field by
// field with the oldest prediction under random back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    localparam int WDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES = 150;
    localparam int N_RANDOM = 1030;

    typedef struct {
        logic [2:0]  kind;
        logic [1:0]  otype;
        logic [63:0] obits;
        logic        oneg;
        logic [1:0]  atype;
        logic [63:0] abits;
        logic        aneg;
        logic        dup;
        bit          drain;
    } t_upd;

    typedef struct {
        logic [1:0]  rtype;
        logic [63:0] bits;
        logic        neg;
        logic [1:0]  err;
        logic [3:0]  size;
    } t_res;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [135:0] s_tdata = '0;
    logic [6:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [71:0]  m_tdata;
    logic [1:0]   m_tuser;

    typed_field_update_alu u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_upd pending_q[$];
    t_res expected_q[$];
    t_upd cur;
    int   n_in = 0, n_out = 0, n_err_res = 0, n_fp_res = 0;
    int   mismatches = 0;
    int   gap_left = 0, stall_left = 0, hold_left = 0, idle_cycles = 0;
    bit   hold_done = 1'b0;

    // ---------------- predictor ----------------

    function automatic int msb_index(input logic [63:0] v);
        int p;
        p = -1;
        for (int i = 0; i < 64; i++) if (v[i]) p = i;
        return p;
    endfunction

    function automatic logic [63:0] single_to_double(input logic [31:0] w);
        logic [63:0] r;
        int p;
        if (w[30:23] == 8'hFF) begin
            if (w[22:0] == 0) r = {w[31], 11'h7FF, 52'd0};
            else r = {w[31], 11'h7FF, 1'b1, w[21:0], 29'd0};  // quietened
        end else if (w[30:23] == 0) begin
            if (w[22:0] == 0) begin
                r = {w[31], 63'd0};
            end else begin
                p = msb_index({41'd0, w[22:0]});
                r = {w[31], 11'(p - 149 + 1023), 52'(({41'd0, w[22:0]} << (52 - p)))};
            end
        end else begin
            r = {w[31], 11'(int'(w[30:23]) - 127 + 1023), w[22:0], 29'd0};
        end
        return r;
    endfunction

    function automatic logic [63:0] int_to_double(input logic [63:0] v, input logic neg);
        logic        s;
        logic [63:0] mag, q, rem, half;
        int p, sh;
        s = neg && v[63];
        mag = s ? -v : v;
        if (mag == 0) return 64'd0;
        p = msb_index(mag);
        if (p <= 52) return {s, 11'(1023 + p), 52'(mag << (52 - p))};
        sh = p - 52;
        q = mag >> sh;
        rem = mag & ((64'd1 << sh) - 1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && q[0])) q = q + 1;
        if (q[53]) begin
            q = q >> 1;
            p++;
        end
        return {s, 11'(1023 + p), q[51:0]};
    endfunction

    function automatic logic [31:0] double_to_single(input logic [63:0] b);
        logic [63:0] sig, q, rem, half;
        int fe, sh;
        if (b[62:52] == 11'h7FF && b[51:0] != 0) return {b[63], 8'hFF, 1'b1, b[50:29]};
        if (b[62:0] >= {1'b0, tfua_pkg::F32_OVF_MAG}) return {b[63], 8'hFF, 23'd0};
        if (b[62:52] == 0) return {b[63], 31'd0};
        fe = int'(b[62:52]) - 1023 + 127;
        sig = {11'd0, 1'b1, b[51:0]};
        sh = (fe >= 1) ? 29 : 29 + 1 - fe;
        if (sh > 54) return {b[63], 31'd0};
        q = sig >> sh;
        rem = sig & ((64'd1 << sh) - 1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && q[0])) q = q + 1;
        if (fe < 1) return {b[63], 31'(q)};
        if (q[24]) begin
            q = q >> 1;
            fe++;
        end
        return {b[63], 8'(fe), q[22:0]};
    endfunction

    function automatic logic [63:0] as_double(input logic [1:0] t, input logic [63:0] v,
                                              input logic neg);
        if (t == tfua_pkg::TYPE_DBL) return v;
        if (t == tfua_pkg::TYPE_FLT) return single_to_double(v[31:0]);
        return int_to_double(v, neg);
    endfunction

    function automatic logic [3:0] msgpack_len(input logic [63:0] v, input logic neg);
        if (neg) begin
            if (v >= 64'hFFFF_FFFF_FFFF_FFE0) return 4'd1;
            if (v >= 64'hFFFF_FFFF_FFFF_FF80) return 4'd2;
            if (v >= 64'hFFFF_FFFF_FFFF_8000) return 4'd3;
            if (v >= 64'hFFFF_FFFF_8000_0000) return 4'd5;
            return 4'd9;
        end
        if (v < 64'h80) return 4'd1;
        if (v < 64'h100) return 4'd2;
        if (v < 64'h1_0000) return 4'd3;
        if (v < 64'h1_0000_0000) return 4'd5;
        return 4'd9;
    endfunction

    function automatic t_res predict_update(input t_upd u);
        t_res r;
        logic [1:0] low;
        logic signed [65:0] a, b, sum;
        real x, y;
        logic [63:0] c;
        r = '{tfua_pkg::TYPE_DBL, 64'd0, 1'b0, tfua_pkg::ERR_NONE, 4'd0};
        if (u.kind > tfua_pkg::KIND_OR) begin
            r.err = tfua_pkg::ERR_TYPE;
        end else if (u.kind >= tfua_pkg::KIND_AND) begin
            if (u.atype != tfua_pkg::TYPE_INT || u.aneg) r.err = tfua_pkg::ERR_TYPE;
            else if (u.dup) r.err = tfua_pkg::ERR_DUP;
            else if (u.otype != tfua_pkg::TYPE_INT || u.oneg) r.err = tfua_pkg::ERR_TYPE;
            else begin
                case (u.kind)
                    tfua_pkg::KIND_AND: r.bits = u.obits & u.abits;
                    tfua_pkg::KIND_XOR: r.bits = u.obits ^ u.abits;
                    default:            r.bits = u.obits | u.abits;
                endcase
                r.rtype = tfua_pkg::TYPE_INT;
                r.size = msgpack_len(r.bits, 1'b0);
            end
        end else begin
            if (u.atype == tfua_pkg::TYPE_NAN) r.err = tfua_pkg::ERR_TYPE;
            else if (u.dup) r.err = tfua_pkg::ERR_DUP;
            else if (u.otype == tfua_pkg::TYPE_NAN) r.err = tfua_pkg::ERR_TYPE;
            else begin
                low = (u.otype < u.atype) ? u.otype : u.atype;
                if (low == tfua_pkg::TYPE_INT) begin
                    a = (u.oneg && u.obits[63]) ? {2'b11, u.obits} : {2'b00, u.obits};
                    b = (u.aneg && u.abits[63]) ? {2'b11, u.abits} : {2'b00, u.abits};
                    sum = (u.kind == tfua_pkg::KIND_SUB) ? a - b : a + b;
                    r.rtype = tfua_pkg::TYPE_INT;
                    r.bits = sum[63:0];
                    if (sum[65:64] == 2'b00) begin
                        r.size = msgpack_len(r.bits, 1'b0);
                    end else if (sum[65:63] == 3'b111) begin
                        r.neg = 1'b1;
                        r.size = msgpack_len(r.bits, 1'b1);
                    end else begin
                        r.err = tfua_pkg::ERR_OVF;
                    end
                end else begin
                    x = $bitstoreal(as_double(u.otype, u.obits, u.oneg));
                    y = $bitstoreal(as_double(u.atype, u.abits, u.aneg));
                    c = $realtobits((u.kind == tfua_pkg::KIND_ADD) ? x + y : x - y);
                    if (low == tfua_pkg::TYPE_DBL) begin
                        r.rtype = tfua_pkg::TYPE_DBL;
                        r.bits = c;
                        r.size = 4'd9;
                    end else begin
                        r.rtype = tfua_pkg::TYPE_FLT;
                        r.bits = {32'd0, double_to_single(c)};
                        r.size = 4'd5;
                    end
                end
            end
        end
        if (r.err != tfua_pkg::ERR_NONE)
            r = '{tfua_pkg::TYPE_DBL, 64'd0, 1'b0, r.err, 4'd0};
        return r;
    endfunction

    // ---------------- stimulus ----------------

    function automatic t_upd mk(input logic [2:0] k, input logic [1:0] ot, input logic [63:0] ob,
                                input logic on, input logic [1:0] at, input logic [63:0] ab,
                                input logic an, input logic d);
        t_upd u;
        u = '{k, ot, ob, on, at, ab, an, d, 1'b0};
        return u;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] rand_operand(input logic [1:0] t);
        logic [63:0] v;
        int sel;
        sel = $urandom_range(0, 9);
        case (t)
            tfua_pkg::TYPE_INT: begin
                case (sel)
                    0, 1: v = 64'($urandom_range(0, 300));
                    2: v = -64'($urandom_range(0, 300));
                    3: v = (64'd1 << $urandom_range(0, 63)) + 64'($urandom_range(0, 4)) - 64'd2;
                    4: v = ~64'($urandom_range(0, 3));
                    5: v = 64'($urandom_range(0, 70000));
                    default: v = rand64() >> $urandom_range(0, 63);
                endcase
            end
            tfua_pkg::TYPE_FLT: begin
                case (sel)
                    0: v = {$urandom, 1'b0, 8'hFF, 23'($urandom_range(0, 3))};
                    1: v = {$urandom, $urandom_range(0, 1) == 1, 8'(0), 23'($urandom)};
                    default: v = {$urandom, $urandom};
                endcase
            end
            default: begin
                case (sel)
                    0, 1, 2: v = int_to_double(rand_operand(tfua_pkg::TYPE_INT), 1'b1);
                    3: v = single_to_double($urandom);
                    4: v = {$urandom_range(0, 1) == 1, 11'($urandom_range(890, 1150)),
                            52'(rand64())};
                    5: v = {$urandom_range(0, 1) == 1, 11'h7FF, 52'($urandom_range(0, 2)) << 50};
                    default: v = rand64();
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic t_upd rand_update();
        t_upd u;
        u.drain = 1'b0;
        u.kind = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                 : 3'($urandom_range(tfua_pkg::KIND_ADD, tfua_pkg::KIND_OR));
        u.otype = ($urandom_range(0, 24) == 0) ? tfua_pkg::TYPE_NAN : 2'($urandom_range(0, 2));
        u.atype = ($urandom_range(0, 24) == 0) ? tfua_pkg::TYPE_NAN : 2'($urandom_range(0, 2));
        // bit operations only get past the checks with integers on both sides
        if (u.kind >= tfua_pkg::KIND_AND && $urandom_range(0, 3) != 0) begin
            u.otype = tfua_pkg::TYPE_INT;
            u.atype = tfua_pkg::TYPE_INT;
        end
        u.obits = rand_operand(u.otype == tfua_pkg::TYPE_NAN ? tfua_pkg::TYPE_INT : u.otype);
        u.abits = rand_operand(u.atype == tfua_pkg::TYPE_NAN ? tfua_pkg::TYPE_INT : u.atype);
        u.oneg = ($urandom_range(0, 4) == 0) ? 1'($urandom) : u.obits[63];
        u.aneg = ($urandom_range(0, 4) == 0) ? 1'($urandom) : u.abits[63];
        if (u.kind >= tfua_pkg::KIND_AND && $urandom_range(0, 3) != 0) begin
            u.oneg = 1'b0;
            u.aneg = 1'b0;
        end
        u.dup = ($urandom_range(0, 11) == 0);
        return u;
    endfunction

    initial begin
        t_upd u;
        // integer bounds and sizes
        pending_q.push_back(mk(tfua_pkg::KIND_ADD, tfua_pkg::TYPE_INT, 64'h7F, 0,
                               tfua_pkg::TYPE_INT, 64'h0, 0, 0));
        pending_q.push_back(mk(tfua_pkg::KIND_ADD, tfua_pkg::TYPE_INT, '1, 0,
                               tfua_pkg::TYPE_INT, 64'h1, 0, 0));
        pending_q.push_back(mk(tfua_pkg::KIND_SUB, tfua_pkg::TYPE_INT, 64'h8000_0000_0000_0000, 1,
                               tfua_pkg::TYPE_INT, 64'h1, 0, 0));
        pending_q.push_back(mk(tfua_pkg::KIND_SUB, tfua_pkg::TYPE_INT, 64'h0, 0,
                               tfua_pkg::TYPE_INT, 64'h20, 0, 0));
        pending_q.push_back(mk(tfua_pkg::KIND_SUB, tfua_pkg::TYPE_INT, 64'hFFFF_FFFF_FFFF_FFDF, 1,
                               tfua_pkg::TYPE_INT, 64'h0, 0, 0));
        pending_q.push_back(mk(tfua_pkg::KIND_ADD, tfua_pkg::TYPE_INT, '1, 1,
                               tfua_pkg::TYPE_INT, '1, 0, 0));
        pending_q.push_back(mk(tfua_pkg::KIND_ADD, tfua_pkg::TYPE_INT, 64'h5, 1,
                               tfua_pkg::TYPE_INT, 64'hFFFF_FFFF, 0, 0));
        // floating paths
        pending_q.push_back(mk(tfua_pkg::KIND_ADD, tfua_pkg::TYPE_DBL, 64'h3FF0_0000_0000_0000, 0,
                               tfua_pkg::TYPE_FLT, 64'h3F80_0000, 0, 0));
        pending_q.push_back(mk(tfua_pkg::KIND_SUB, tfua_pkg::TYPE_FLT, 64'h7F7F_FFFF, 0,
                               tfua_pkg::TYPE_FLT, 64'hFF7F_FFFF, 1, 0));
        pending_q.push_back(mk(tfua_pkg::KIND_ADD, tfua_pkg::TYPE_FLT, 64'h7FA0_0001, 0,
                               tfua_pkg::TYPE_INT, 64'h3, 0, 0));
        pending_q.push_back(mk(tfua_pkg::KIND_ADD, tfua_pkg::TYPE_INT, '1, 0,
                               tfua_pkg::TYPE_FLT, 64'h0000_0001, 0, 0));
        pending_q.push_back(mk(tfua_pkg::KIND_SUB, tfua_pkg::TYPE_DBL, 64'h7FF0_0000_0000_0000, 0,
                               tfua_pkg::TYPE_DBL, 64'h7FF0_0000_0000_0000, 0, 0));
        pending_q.push_back(mk(tfua_pkg::KIND_ADD, tfua_pkg::TYPE_FLT, 64'h0080_0000, 0,
                               tfua_pkg::TYPE_FLT, 64'h8000_0001, 0, 0));
        // bitwise
        pending_q.push_back(mk(tfua_pkg::KIND_AND, tfua_pkg::TYPE_INT, '1, 0,
                               tfua_pkg::TYPE_INT, 64'hFF00, 0, 0));
        pending_q.push_back(mk(tfua_pkg::KIND_XOR, tfua_pkg::TYPE_INT, '1, 0,
                               tfua_pkg::TYPE_INT, 64'h0, 0, 0));
        pending_q.push_back(mk(tfua_pkg::KIND_OR, tfua_pkg::TYPE_INT, 64'h1_0000_0000, 0,
                               tfua_pkg::TYPE_INT, 64'h7F, 0, 0));
        pending_q.push_back(mk(tfua_pkg::KIND_OR, tfua_pkg::TYPE_INT, 64'h1, 0,
                               tfua_pkg::TYPE_INT, 64'h1, 1, 0));
        pending_q.push_back(mk(tfua_pkg::KIND_AND, tfua_pkg::TYPE_INT, 64'h1, 1,
                               tfua_pkg::TYPE_INT, 64'h1, 0, 0));
        pending_q.push_back(mk(tfua_pkg::KIND_XOR, tfua_pkg::TYPE_DBL, 64'h1, 0,
                               tfua_pkg::TYPE_INT, 64'h1, 0, 0));
        pending_q.push_back(mk(tfua_pkg::KIND_AND, tfua_pkg::TYPE_INT, 64'h1, 0,
                               tfua_pkg::TYPE_FLT, 64'h1, 0, 1));
        // errors and their order
        pending_q.push_back(mk(tfua_pkg::KIND_ADD, tfua_pkg::TYPE_NAN, 64'h1, 0,
                               tfua_pkg::TYPE_INT, 64'h1, 0, 1));
        pending_q.push_back(mk(tfua_pkg::KIND_ADD, tfua_pkg::TYPE_NAN, 64'h1, 0,
                               tfua_pkg::TYPE_INT, 64'h1, 0, 0));
        pending_q.push_back(mk(tfua_pkg::KIND_SUB, tfua_pkg::TYPE_INT, 64'h1, 0,
                               tfua_pkg::TYPE_NAN, 64'h1, 0, 1));
        pending_q.push_back(mk(3'd5, tfua_pkg::TYPE_INT, 64'h1, 0,
                               tfua_pkg::TYPE_INT, 64'h1, 0, 0));
        pending_q.push_back(mk(3'd7, tfua_pkg::TYPE_DBL, '1, 1,
                               tfua_pkg::TYPE_NAN, '1, 1, 1));
        for (int i = 0; i < N_RANDOM; i++) begin
            u = rand_update();
            if (i == 600) u.drain = 1'b1;  // wait for the pipe to empty first
            pending_q.push_back(u);
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_q.size() == 0 && !s_tvalid);
        wait (expected_q.size() == 0);
        repeat (20) @(posedge i_clk);
        $display("Run covered %0d updates and %0d results (%0d with an error, %0d floating).",
                 n_in, n_out, n_err_res, n_fp_res);
        $display("Long sink hold-off and a full drain before one update were exercised.");
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // ---------------- driver ----------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_q.push_back(predict_update(cur));
                n_in++;
            end
            if (s_tvalid && !s_tready) begin
                // hold the offered transaction
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (pending_q.size() > 0 &&
                         (!pending_q[0].drain || expected_q.size() == 0)) begin
                cur = pending_q.pop_front();
                s_tdata <= {5'd0, cur.dup, cur.aneg, cur.abits, cur.oneg, cur.obits};
                s_tuser <= {cur.atype, cur.otype, cur.kind};
                s_tvalid <= 1'b1;
                gap_left <= ((n_in % 200) < 60) ? 0 : $urandom_range(0, 8);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------- monitor ----------------

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && n_out >= 400) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_res e;
        int s;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            stall_left <= 0;
        end else begin
            s = stall_left;
            if (m_tvalid && m_tready) begin
                n_out++;
                s = ((n_out % 250) < 70) ? 0 : $urandom_range(0, 8);
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result transaction %h", m_tdata);
                end else begin
                    e = expected_q.pop_front();
                    if (e.err != tfua_pkg::ERR_NONE) n_err_res++;
                    else if (e.rtype != tfua_pkg::TYPE_INT) n_fp_res++;
                    if (m_tuser != e.rtype || m_tdata[63:0] != e.bits || m_tdata[64] != e.neg ||
                        m_tdata[66:65] != e.err || m_tdata[70:67] != e.size ||
                        m_tdata[71] != 1'b0) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: exp type %0d bits %h neg %b err %0d size %0d,",
                                     n_out, e.rtype, e.bits, e.neg, e.err, e.size,
                                     " got type %0d bits %h neg %b err %0d size %0d",
                                     m_tuser, m_tdata[63:0], m_tdata[64], m_tdata[66:65],
                                     m_tdata[70:67]);
                    end
                end
            end
            if (s > 0) begin
                stall_left <= s - 1;
                m_tready <= 1'b0;
            end else begin
                stall_left <= 0;
                m_tready <= (hold_left == 0);
            end
        end
    end

    // ---------------- watchdog ----------------

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WDOG_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", WDOG_LIMIT);
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

`default_nettype wire
